// ===== rtl/core/apmm_pkg.sv =====
// constants and types shared by the attitude pid motor mixer
package apmm_pkg;

  localparam int PWM_W     = 11;
  localparam int ANG_W     = 16;
  localparam int ERR_W     = ANG_W + 1;
  localparam int DIFF_W    = ERR_W + 1;
  localparam int GAIN_W    = 16;
  localparam int GAINS_W   = 3 * GAIN_W;
  localparam int THR_W     = 10;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_W    = 8;

  // kp or ki times error, exact
  localparam int PROD_W = GAIN_W + ERR_W + 1;
  // kd times error change magnitude
  localparam int DMAG_W = GAIN_W + DIFF_W - 1;

  // divide by 100 as a shift by 2 then a reciprocal multiply by 1/25
  localparam int    D_DIVISOR = 100;
  localparam int    DIV_PRE   = 2;
  localparam int    DIV_SMALL = D_DIVISOR / (1 << DIV_PRE);
  localparam int    DIV_SHIFT = 36;
  localparam longint DIV_RECIP = (64'sd1 <<< DIV_SHIFT) / DIV_SMALL;
  localparam int    DY_W      = DMAG_W - DIV_PRE;
  localparam int    DREC_W    = DY_W + 32;
  localparam int    QE_W      = DREC_W - DIV_SHIFT;
  localparam int    REM_W     = DY_W + 1;
  localparam int    Q_W       = QE_W + 1;
  localparam int    D_W       = Q_W + 1;

  localparam int     RESP_LIM_BIT = 56;
  localparam longint RESP_LIMIT   = 64'sd1 <<< RESP_LIM_BIT;
  localparam int     RESP_W       = RESP_LIM_BIT + 2;
  localparam int     MIX_W        = RESP_W + 2;

  localparam int PWM_MIN      = 1000;
  localparam int PWM_MID      = 1500;
  localparam int PWM_HIGH_RST = 2000;
  localparam int THR_MIN      = 75;
  localparam int YAW_HALF     = 18000;
  localparam int YAW_TURN     = 36000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROLL_GAINS    = 3'd0,
    CFG_PITCH_GAINS   = 3'd1,
    CFG_YAW_GAINS     = 3'd2,
    CFG_THROTTLE_IDLE = 3'd3,
    CFG_PWM_HIGH      = 3'd4,
    CFG_VEHICLE_TYPE  = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    VEH_QUAD_X = 1'b0,
    VEH_PAIR   = 1'b1
  } vehicle_e;

endpackage

// ===== rtl/core/attitude_pid_motor_mixer_top.sv =====
// attitude pid controller for roll, pitch and yaw with quad-x or yaw/throttle output mixer
//
// Fully pipelined: one request per clock sustained while the result port is not stalled, and its
// six pwm values reach the result port through the input register, product stage, reciprocal
// divide stage, response stage and result register. The integrators and the last
// errors update as an armed request leaves the input register, so back-to-back requests
// see each other's pid state. Each stage holds under back pressure and empty stages still
// take new requests, so the input stalls only once all five registers are full. The result
// register also holds the six outputs between requests. Configuration is written through
// cfg_we_i, cfg_index_i and cfg_data_i and is used live by the product and output stages.
module attitude_pid_motor_mixer_top #(
  parameter int INTEGRATOR_BITS = 40
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [apmm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [apmm_pkg::GAINS_W-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                armed_i,
  input  logic signed [apmm_pkg::ANG_W-1:0]   meas_roll_i,
  input  logic signed [apmm_pkg::ANG_W-1:0]   meas_pitch_i,
  input  logic signed [apmm_pkg::ANG_W-1:0]   meas_yaw_i,
  input  logic signed [apmm_pkg::ANG_W-1:0]   want_roll_i,
  input  logic signed [apmm_pkg::ANG_W-1:0]   want_pitch_i,
  input  logic signed [apmm_pkg::ANG_W-1:0]   want_yaw_i,
  input  logic [apmm_pkg::THR_W-1:0]          want_throttle_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [apmm_pkg::PWM_W-1:0]          front_left_pwm_o,
  output logic [apmm_pkg::PWM_W-1:0]          front_right_pwm_o,
  output logic [apmm_pkg::PWM_W-1:0]          back_left_pwm_o,
  output logic [apmm_pkg::PWM_W-1:0]          back_right_pwm_o,
  output logic [apmm_pkg::PWM_W-1:0]          yaw_pwm_o,
  output logic [apmm_pkg::PWM_W-1:0]          throttle_pwm_o
);

  localparam int IB     = INTEGRATOR_BITS;
  localparam int ISUM_W = ((IB > apmm_pkg::PROD_W) ? IB : apmm_pkg::PROD_W) + 1;
  localparam int RSUM_W = ((IB > apmm_pkg::RESP_LIM_BIT) ? IB : apmm_pkg::RESP_LIM_BIT) + 2;
  localparam logic signed [RSUM_W-1:0] RLIM_P = RSUM_W'(apmm_pkg::RESP_LIMIT);
  localparam logic signed [RSUM_W-1:0] RLIM_N = -RLIM_P;

  localparam int PW = apmm_pkg::PWM_W;
  localparam int MW = apmm_pkg::MIX_W;

  // configuration registers
  logic [apmm_pkg::GAINS_W-1:0] gains_q [3];
  logic [apmm_pkg::THR_W-1:0]   idle_q;
  logic [PW-1:0]                pwm_high_q;
  apmm_pkg::vehicle_e           veh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        gains_q[a] <= '0;
      end
      idle_q     <= '0;
      pwm_high_q <= PW'(apmm_pkg::PWM_HIGH_RST);
      veh_q      <= apmm_pkg::VEH_QUAD_X;
    end else if (cfg_we_i) begin
      case (apmm_pkg::cfg_idx_e'(cfg_index_i))
        apmm_pkg::CFG_ROLL_GAINS:    gains_q[0] <= cfg_data_i;
        apmm_pkg::CFG_PITCH_GAINS:   gains_q[1] <= cfg_data_i;
        apmm_pkg::CFG_YAW_GAINS:     gains_q[2] <= cfg_data_i;
        apmm_pkg::CFG_THROTTLE_IDLE: idle_q     <= cfg_data_i[apmm_pkg::THR_W-1:0];
        apmm_pkg::CFG_PWM_HIGH:      pwm_high_q <= cfg_data_i[PW-1:0];
        apmm_pkg::CFG_VEHICLE_TYPE:  veh_q      <= apmm_pkg::vehicle_e'(cfg_data_i[0]);
        default: begin
        end
      endcase
    end
  end

  // pipeline control
  logic v0_q, v1_q, v2_q, v3_q, out_vld_q;
  logic rdy0, rdy1, rdy2, rdy3, rdy_out;
  logic in_acc, adv0, adv1, adv2, adv3;

  assign rdy_out    = !out_vld_q || !out_stall_i;
  assign rdy3       = !v3_q || rdy_out;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign rdy0       = !v0_q || rdy1;
  assign in_stall_o = !rdy0;
  assign in_acc     = in_valid_i && rdy0;
  assign adv0       = v0_q && rdy1;
  assign adv1       = v1_q && rdy2;
  assign adv2       = v2_q && rdy3;
  assign adv3       = v3_q && rdy_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q      <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (rdy0)    v0_q      <= in_valid_i;
      if (rdy1)    v1_q      <= v0_q;
      if (rdy2)    v2_q      <= v1_q;
      if (rdy3)    v3_q      <= v2_q;
      if (rdy_out) out_vld_q <= v3_q;
    end
  end

  // input register
  logic                              arm0_q;
  logic signed [apmm_pkg::ANG_W-1:0] meas_q [3];
  logic signed [apmm_pkg::ANG_W-1:0] want_q [3];
  logic [apmm_pkg::THR_W-1:0]        thr0_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      arm0_q    <= armed_i;
      meas_q[0] <= meas_roll_i;
      meas_q[1] <= meas_pitch_i;
      meas_q[2] <= meas_yaw_i;
      want_q[0] <= want_roll_i;
      want_q[1] <= want_pitch_i;
      want_q[2] <= want_yaw_i;
      thr0_q    <= want_throttle_i;
    end
  end

  // pid state
  logic signed [IB-1:0]              integ_q    [3];
  logic signed [apmm_pkg::ERR_W-1:0] last_err_q [3];

  // stage 1: errors, products, integrator update
  logic signed [apmm_pkg::ERR_W-1:0]  err_raw [3];
  logic signed [apmm_pkg::ERR_W-1:0]  err_d   [3];
  logic signed [apmm_pkg::ERR_W:0]    yaw_ext;
  logic signed [apmm_pkg::ERR_W:0]    yaw_wrap;
  logic signed [apmm_pkg::PROD_W-1:0] err_x   [3];
  logic signed [apmm_pkg::PROD_W-1:0] kp_x    [3];
  logic signed [apmm_pkg::PROD_W-1:0] ki_x    [3];
  logic signed [apmm_pkg::PROD_W-1:0] p_d     [3];
  logic signed [apmm_pkg::PROD_W-1:0] inc_d   [3];
  logic signed [ISUM_W-1:0]           isum    [3];
  logic signed [IB-1:0]               ig_d    [3];
  logic signed [apmm_pkg::DIFF_W-1:0] diff    [3];
  logic [apmm_pkg::DIFF_W-1:0]        dabs    [3];
  logic [apmm_pkg::DMAG_W-1:0]        dmag    [3];
  logic                               dneg_d  [3];
  logic [apmm_pkg::DY_W-1:0]          dy_d    [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      err_raw[a] = apmm_pkg::ERR_W'(meas_q[a]) - apmm_pkg::ERR_W'(want_q[a]);
    end
    // yaw error into half a turn
    yaw_ext = (apmm_pkg::ERR_W+1)'(err_raw[2]);
    if (yaw_ext > 3 * apmm_pkg::YAW_HALF) begin
      yaw_wrap = yaw_ext - (apmm_pkg::ERR_W+1)'(2 * apmm_pkg::YAW_TURN);
    end else if (yaw_ext > apmm_pkg::YAW_HALF) begin
      yaw_wrap = yaw_ext - (apmm_pkg::ERR_W+1)'(apmm_pkg::YAW_TURN);
    end else if (yaw_ext <= -3 * apmm_pkg::YAW_HALF) begin
      yaw_wrap = yaw_ext + (apmm_pkg::ERR_W+1)'(2 * apmm_pkg::YAW_TURN);
    end else if (yaw_ext <= -apmm_pkg::YAW_HALF) begin
      yaw_wrap = yaw_ext + (apmm_pkg::ERR_W+1)'(apmm_pkg::YAW_TURN);
    end else begin
      yaw_wrap = yaw_ext;
    end
    err_d[0] = err_raw[0];
    err_d[1] = err_raw[1];
    err_d[2] = apmm_pkg::ERR_W'(yaw_wrap);

    for (int a = 0; a < 3; a++) begin
      err_x[a] = apmm_pkg::PROD_W'(err_d[a]);
      kp_x[a]  = apmm_pkg::PROD_W'({1'b0, gains_q[a][apmm_pkg::GAIN_W-1:0]});
      ki_x[a]  = apmm_pkg::PROD_W'({1'b0, gains_q[a][2*apmm_pkg::GAIN_W-1:apmm_pkg::GAIN_W]});
      p_d[a]   = kp_x[a] * err_x[a];
      inc_d[a] = ki_x[a] * err_x[a];
      isum[a]  = ISUM_W'(integ_q[a]) + ISUM_W'(inc_d[a]);
      // saturate to the integrator range
      if ((&isum[a][ISUM_W-1:IB-1]) || !(|isum[a][ISUM_W-1:IB-1])) begin
        ig_d[a] = isum[a][IB-1:0];
      end else if (isum[a][ISUM_W-1]) begin
        ig_d[a] = {1'b1, {(IB-1){1'b0}}};
      end else begin
        ig_d[a] = {1'b0, {(IB-1){1'b1}}};
      end
      diff[a]   = apmm_pkg::DIFF_W'(err_d[a]) - apmm_pkg::DIFF_W'(last_err_q[a]);
      dneg_d[a] = diff[a][apmm_pkg::DIFF_W-1];
      dabs[a]   = dneg_d[a] ? apmm_pkg::DIFF_W'(-diff[a]) : diff[a];
      dmag[a]   = apmm_pkg::DMAG_W'(gains_q[a][apmm_pkg::GAINS_W-1:2*apmm_pkg::GAIN_W])
                * apmm_pkg::DMAG_W'(dabs[a][apmm_pkg::DIFF_W-2:0]);
      dy_d[a]   = dmag[a][apmm_pkg::DMAG_W-1:apmm_pkg::DIV_PRE];
    end
  end

  logic                               arm1_q;
  logic [apmm_pkg::THR_W-1:0]         thr1_q;
  logic signed [apmm_pkg::PROD_W-1:0] p1_q    [3];
  logic signed [IB-1:0]               ig1_q   [3];
  logic                               dneg1_q [3];
  logic [apmm_pkg::DY_W-1:0]          dy1_q   [3];

  always_ff @(posedge clk_i) begin
    if (adv0) begin
      arm1_q <= arm0_q;
      thr1_q <= thr0_q;
      for (int a = 0; a < 3; a++) begin
        p1_q[a]    <= p_d[a];
        ig1_q[a]   <= ig_d[a];
        dneg1_q[a] <= dneg_d[a];
        dy1_q[a]   <= dy_d[a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        integ_q[a]    <= '0;
        last_err_q[a] <= '0;
      end
    end else if (adv0 && arm0_q) begin
      for (int a = 0; a < 3; a++) begin
        integ_q[a]    <= ig_d[a];
        last_err_q[a] <= err_d[a];
      end
    end
  end

  // stage 2: reciprocal multiply for the derivative divide
  logic [apmm_pkg::DREC_W-1:0] drec [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      drec[a] = apmm_pkg::DREC_W'(dy1_q[a]) * apmm_pkg::DREC_W'(apmm_pkg::DIV_RECIP);
    end
  end

  logic                               arm2_q;
  logic [apmm_pkg::THR_W-1:0]         thr2_q;
  logic signed [apmm_pkg::PROD_W-1:0] p2_q    [3];
  logic signed [IB-1:0]               ig2_q   [3];
  logic                               dneg2_q [3];
  logic [apmm_pkg::DY_W-1:0]          dy2_q   [3];
  logic [apmm_pkg::QE_W-1:0]          qe2_q   [3];

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      arm2_q <= arm1_q;
      thr2_q <= thr1_q;
      for (int a = 0; a < 3; a++) begin
        p2_q[a]    <= p1_q[a];
        ig2_q[a]   <= ig1_q[a];
        dneg2_q[a] <= dneg1_q[a];
        dy2_q[a]   <= dy1_q[a];
        qe2_q[a]   <= drec[a][apmm_pkg::DREC_W-1:apmm_pkg::DIV_SHIFT];
      end
    end
  end

  // stage 3: quotient correction and axis response
  logic [apmm_pkg::REM_W-1:0]         rem   [3];
  logic [apmm_pkg::Q_W-1:0]           quo   [3];
  logic signed [apmm_pkg::D_W-1:0]    dterm [3];
  logic signed [RSUM_W-1:0]           rsum  [3];
  logic signed [apmm_pkg::RESP_W-1:0] resp_d [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rem[a] = apmm_pkg::REM_W'(dy2_q[a])
             - apmm_pkg::REM_W'(qe2_q[a]) * apmm_pkg::REM_W'(apmm_pkg::DIV_SMALL);
      quo[a] = apmm_pkg::Q_W'(qe2_q[a])
             + apmm_pkg::Q_W'(rem[a] >= apmm_pkg::REM_W'(apmm_pkg::DIV_SMALL));
      dterm[a] = dneg2_q[a] ? -$signed({1'b0, quo[a]}) : $signed({1'b0, quo[a]});
      rsum[a]  = RSUM_W'(p2_q[a]) + RSUM_W'(ig2_q[a]) - RSUM_W'(dterm[a]);
      if (rsum[a] > RLIM_P) begin
        resp_d[a] = apmm_pkg::RESP_W'(RLIM_P);
      end else if (rsum[a] < RLIM_N) begin
        resp_d[a] = apmm_pkg::RESP_W'(RLIM_N);
      end else begin
        resp_d[a] = apmm_pkg::RESP_W'(rsum[a]);
      end
    end
  end

  logic                               arm3_q;
  logic [apmm_pkg::THR_W-1:0]         thr3_q;
  logic signed [apmm_pkg::RESP_W-1:0] resp3_q [3];

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      arm3_q <= arm2_q;
      thr3_q <= thr2_q;
      for (int a = 0; a < 3; a++) begin
        resp3_q[a] <= resp_d[a];
      end
    end
  end

  // output stage: mixer and clamps
  function automatic logic [PW-1:0] clamp_int(input logic [PW:0]   x,
                                              input logic [PW-1:0] ph);
    logic [PW:0] lo_x;
    lo_x = (x < (PW+1)'(apmm_pkg::PWM_MIN)) ? (PW+1)'(apmm_pkg::PWM_MIN) : x;
    return (lo_x > {1'b0, ph}) ? ph : lo_x[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] clamp_q8(input logic signed [MW-1:0] s,
                                             input logic [PW-1:0]        ph);
    logic [MW-apmm_pkg::FRAC_W-1:0] whole;
    logic [PW-1:0]                  res;
    whole = s[MW-1:apmm_pkg::FRAC_W];
    if (s < MW'(apmm_pkg::PWM_MIN * (1 << apmm_pkg::FRAC_W))) begin
      res = clamp_int((PW+1)'(apmm_pkg::PWM_MIN), ph);
    end else if (whole > (MW-apmm_pkg::FRAC_W)'(ph)) begin
      res = ph;
    end else begin
      res = whole[PW-1:0];
    end
    return res;
  endfunction

  logic [PW-1:0]           held_q [6];
  logic [PW-1:0]           held_d [6];
  logic [PW-1:0]           thr_sum;
  logic signed [MW-1:0]    base;
  logic signed [MW-1:0]    rr, rp, ry;

  always_comb begin
    thr_sum = {1'b0, idle_q} + {1'b0, thr3_q};
    base    = MW'(thr_sum) << apmm_pkg::FRAC_W;
    rr      = MW'(resp3_q[0]);
    rp      = MW'(resp3_q[1]);
    ry      = MW'(resp3_q[2]);
    if (!arm3_q) begin
      for (int i = 0; i < 4; i++) begin
        held_d[i] = PW'(apmm_pkg::PWM_MIN);
      end
      held_d[4] = PW'(apmm_pkg::PWM_MID);
      held_d[5] = PW'(apmm_pkg::PWM_MID);
    end else begin
      for (int i = 0; i < 6; i++) begin
        held_d[i] = clamp_int({1'b0, held_q[i]}, pwm_high_q);
      end
      if (veh_q == apmm_pkg::VEH_QUAD_X) begin
        if (thr3_q < apmm_pkg::THR_W'(apmm_pkg::THR_MIN)) begin
          for (int i = 0; i < 4; i++) begin
            held_d[i] = clamp_int((PW+1)'(apmm_pkg::PWM_MIN), pwm_high_q);
          end
        end else begin
          held_d[0] = clamp_q8(base - rr + rp - ry, pwm_high_q);
          held_d[1] = clamp_q8(base + rr + rp + ry, pwm_high_q);
          held_d[2] = clamp_q8(base - rr - rp + ry, pwm_high_q);
          held_d[3] = clamp_q8(base + rr - rp - ry, pwm_high_q);
        end
      end else begin
        held_d[4] = clamp_q8(MW'(apmm_pkg::PWM_MID * (1 << apmm_pkg::FRAC_W)) + ry,
                             pwm_high_q);
        held_d[5] = clamp_int((PW+1)'(apmm_pkg::PWM_MID) + (PW+1)'(thr3_q), pwm_high_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        held_q[i] <= '0;
      end
    end else if (adv3) begin
      for (int i = 0; i < 6; i++) begin
        held_q[i] <= held_d[i];
      end
    end
  end

  assign out_valid_o       = out_vld_q;
  assign front_left_pwm_o  = held_q[0];
  assign front_right_pwm_o = held_q[1];
  assign back_left_pwm_o   = held_q[2];
  assign back_right_pwm_o  = held_q[3];
  assign yaw_pwm_o         = held_q[4];
  assign throttle_pwm_o    = held_q[5];

  // disarmed request gives the safe values
  a_disarmed_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv3 && !arm3_q |=> front_left_pwm_o == PW'(apmm_pkg::PWM_MIN)
                     && yaw_pwm_o == PW'(apmm_pkg::PWM_MID)
                     && throttle_pwm_o == PW'(apmm_pkg::PWM_MID))
    else $error("disarmed request did not give safe outputs");

  // armed outputs stay inside the clamp window
  a_armed_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv3 && arm3_q && pwm_high_q >= PW'(apmm_pkg::PWM_MIN)
    |=> front_left_pwm_o >= PW'(apmm_pkg::PWM_MIN)
     && front_left_pwm_o <= $past(pwm_high_q)
     && back_right_pwm_o <= $past(pwm_high_q)
     && yaw_pwm_o >= PW'(apmm_pkg::PWM_MIN)
     && yaw_pwm_o <= $past(pwm_high_q))
    else $error("armed output outside clamp window");

  // pid state changes only when an armed request enters the product stage
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adv0 && arm0_q) |=> integ_q[0] == $past(integ_q[0])
                       && integ_q[2] == $past(integ_q[2])
                       && last_err_q[1] == $past(last_err_q[1]))
    else $error("pid state changed without an armed request");

  // input stalls only with every stage full behind a stalled result
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> v0_q && v1_q && v2_q && v3_q && out_vld_q && out_stall_i)
    else $error("input stalled with room in the pipeline");

  // a result never appears without a request in the response stage register before it
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q && !v3_q |=> !out_vld_q)
    else $error("result appeared without a request");

endmodule

// ===== tb/tb_top.sv =====
// testbench for the attitude pid motor mixer: pwm results checked against an in-bench predictor
module tb_top;

  localparam int     INTEG_BITS     = 40;
  localparam int     CLK_HALF       = 5;
  localparam int     RESET_CYCLES   = 3;
  localparam int     SETTLE_CYCLES  = 8;
  localparam longint RUN_LIMIT      = 3000000;
  localparam int     MAX_REPORTS    = 10;
  localparam int     NUM_AXES       = 3;
  localparam int     NUM_PWM        = 6;
  localparam int     NUM_PHASES     = 6;
  localparam int     PHASE_TICKS    = 150;
  localparam int     AX_ROLL        = 0;
  localparam int     AX_PITCH       = 1;
  localparam int     AX_YAW         = 2;
  localparam int     OUT_FL         = 0;
  localparam int     OUT_FR         = 1;
  localparam int     OUT_BL         = 2;
  localparam int     OUT_BR         = 3;
  localparam int     OUT_YAW        = 4;
  localparam int     OUT_THR        = 5;
  localparam int     PWM_FLOOR      = 1000;
  localparam int     PWM_CENTER     = 1500;
  localparam int     THR_IDLE_BELOW = 75;
  localparam int     D_SCALE        = 100;
  localparam int     Q8_ONE         = 256;
  localparam int     YAW_HALF_TURN  = 18000;
  localparam int     YAW_FULL_TURN  = 36000;
  localparam longint RESP_SAT       = 64'sd1 <<< 56;

  typedef logic signed [apmm_pkg::ANG_W-1:0] ang_t;
  typedef logic [apmm_pkg::THR_W-1:0]        thr_t;
  typedef logic [apmm_pkg::PWM_W-1:0]        pwm_t;
  typedef logic [apmm_pkg::GAIN_W-1:0]       gain_t;
  typedef logic [apmm_pkg::GAINS_W-1:0]      gains_t;

  typedef struct packed {
    logic armed;
    ang_t meas_roll;
    ang_t meas_pitch;
    ang_t meas_yaw;
    ang_t want_roll;
    ang_t want_pitch;
    ang_t want_yaw;
    thr_t want_throttle;
  } tick_t;

  typedef logic [NUM_PWM-1:0][apmm_pkg::PWM_W-1:0] pwm_set_t;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_e;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [apmm_pkg::CFG_IDX_W-1:0] cfg_index_i = apmm_pkg::CFG_ROLL_GAINS;
  gains_t                         cfg_data_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic                           armed_i = 1'b0;
  ang_t                           meas_roll_i = '0;
  ang_t                           meas_pitch_i = '0;
  ang_t                           meas_yaw_i = '0;
  ang_t                           want_roll_i = '0;
  ang_t                           want_pitch_i = '0;
  ang_t                           want_yaw_i = '0;
  thr_t                           want_throttle_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  pwm_t                           front_left_pwm_o;
  pwm_t                           front_right_pwm_o;
  pwm_t                           back_left_pwm_o;
  pwm_t                           back_right_pwm_o;
  pwm_t                           yaw_pwm_o;
  pwm_t                           throttle_pwm_o;

  // predictor copy of configuration and controller state
  gains_t             gains_q [NUM_AXES];
  thr_t               idle_q;
  pwm_t               pwm_high_q;
  apmm_pkg::vehicle_e vehicle_q;
  int                 prev_err [NUM_AXES];
  longint             integ [NUM_AXES];
  pwm_set_t           held_pwm;
  pwm_set_t           pwm_expected [$];

  int       failures = 0;
  int       burst_left = 0;
  bit       tx_steady = 1'b0;
  int       hold_len = 0;
  int       hold_seq = 0;
  int       hold_seen = 0;
  int       hold_left = 0;
  rx_mode_e rx_mode = RX_FREE;
  int       rx_left = 0;
  pwm_set_t result_got;
  pwm_set_t result_want;
  string    pwm_name [NUM_PWM] = '{"front_left", "front_right", "back_left", "back_right",
                                   "yaw", "throttle"};

  attitude_pid_motor_mixer_top #(
    .INTEGRATOR_BITS(INTEG_BITS)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .armed_i          (armed_i),
    .meas_roll_i      (meas_roll_i),
    .meas_pitch_i     (meas_pitch_i),
    .meas_yaw_i       (meas_yaw_i),
    .want_roll_i      (want_roll_i),
    .want_pitch_i     (want_pitch_i),
    .want_yaw_i       (want_yaw_i),
    .want_throttle_i  (want_throttle_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .front_left_pwm_o (front_left_pwm_o),
    .front_right_pwm_o(front_right_pwm_o),
    .back_left_pwm_o  (back_left_pwm_o),
    .back_right_pwm_o (back_right_pwm_o),
    .yaw_pwm_o        (yaw_pwm_o),
    .throttle_pwm_o   (throttle_pwm_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  function automatic pwm_t clamp_pwm(longint x);
    longint ceiling;
    ceiling = longint'(pwm_high_q);
    if (x < PWM_FLOOR) x = PWM_FLOOR;
    if (x > ceiling) x = ceiling;
    return pwm_t'(x);
  endfunction

  function automatic longint axis_response(int axis, int err, gains_t g);
    longint kp, ki, kd, p, d, acc, hi, lo;
    kp = longint'(g[apmm_pkg::GAIN_W-1:0]);
    ki = longint'(g[2*apmm_pkg::GAIN_W-1:apmm_pkg::GAIN_W]);
    kd = longint'(g[3*apmm_pkg::GAIN_W-1:2*apmm_pkg::GAIN_W]);
    hi = (64'sd1 <<< (INTEG_BITS - 1)) - 1;
    lo = -hi - 1;
    p = kp * err;
    d = kd * (longint'(err) - prev_err[axis]) / D_SCALE;
    acc = integ[axis] + ki * err;
    if (acc > hi) acc = hi;
    if (acc < lo) acc = lo;
    integ[axis] = acc;
    prev_err[axis] = err;
    acc = p + acc - d;
    if (acc > RESP_SAT) acc = RESP_SAT;
    if (acc < -RESP_SAT) acc = -RESP_SAT;
    return acc;
  endfunction

  function automatic pwm_set_t predict_tick(tick_t t);
    int     err [NUM_AXES];
    longint resp [NUM_AXES];
    longint base;
    int     thr;
    int     a;
    thr = int'(t.want_throttle);
    if (t.armed) begin
      err[AX_ROLL]  = int'(t.meas_roll) - int'(t.want_roll);
      err[AX_PITCH] = int'(t.meas_pitch) - int'(t.want_pitch);
      err[AX_YAW]   = int'(t.meas_yaw) - int'(t.want_yaw);
      while (err[AX_YAW] > YAW_HALF_TURN) err[AX_YAW] -= YAW_FULL_TURN;
      while (err[AX_YAW] <= -YAW_HALF_TURN) err[AX_YAW] += YAW_FULL_TURN;
      for (a = 0; a < NUM_AXES; a++) resp[a] = axis_response(a, err[a], gains_q[a]);
      if (vehicle_q == apmm_pkg::VEH_QUAD_X) begin
        if (thr < THR_IDLE_BELOW) begin
          for (a = OUT_FL; a <= OUT_BR; a++) held_pwm[a] = pwm_t'(PWM_FLOOR);
        end else begin
          base = longint'(idle_q);
          base = (base + thr) * Q8_ONE;
          held_pwm[OUT_FL] = clamp_pwm((base - resp[AX_ROLL] + resp[AX_PITCH]
                                        - resp[AX_YAW]) / Q8_ONE);
          held_pwm[OUT_FR] = clamp_pwm((base + resp[AX_ROLL] + resp[AX_PITCH]
                                        + resp[AX_YAW]) / Q8_ONE);
          held_pwm[OUT_BL] = clamp_pwm((base - resp[AX_ROLL] - resp[AX_PITCH]
                                        + resp[AX_YAW]) / Q8_ONE);
          held_pwm[OUT_BR] = clamp_pwm((base + resp[AX_ROLL] - resp[AX_PITCH]
                                        - resp[AX_YAW]) / Q8_ONE);
        end
      end else begin
        base = PWM_CENTER;
        held_pwm[OUT_YAW] = clamp_pwm((base * Q8_ONE + resp[AX_YAW]) / Q8_ONE);
        held_pwm[OUT_THR] = clamp_pwm(base + thr);
      end
      for (a = 0; a < NUM_PWM; a++) held_pwm[a] = clamp_pwm(longint'(held_pwm[a]));
    end else begin
      for (a = OUT_FL; a <= OUT_BR; a++) held_pwm[a] = pwm_t'(PWM_FLOOR);
      held_pwm[OUT_YAW] = pwm_t'(PWM_CENTER);
      held_pwm[OUT_THR] = pwm_t'(PWM_CENTER);
    end
    return held_pwm;
  endfunction

  function automatic tick_t make_tick(logic armed, int mr, int mp, int my, int wr, int wp,
                                      int wy, int thr);
    tick_t t;
    t.armed         = armed;
    t.meas_roll     = ang_t'(mr);
    t.meas_pitch    = ang_t'(mp);
    t.meas_yaw      = ang_t'(my);
    t.want_roll     = ang_t'(wr);
    t.want_pitch    = ang_t'(wp);
    t.want_yaw      = ang_t'(wy);
    t.want_throttle = thr_t'(thr);
    return t;
  endfunction

  function automatic int rand_angle();
    if ($urandom_range(0, 6) == 0) return int'(ang_t'($urandom()));
    return int'($urandom_range(0, YAW_FULL_TURN)) - YAW_HALF_TURN;
  endfunction

  function automatic int near_angle(int target);
    if ($urandom_range(0, 4) < 3) return target + int'($urandom_range(0, 1000)) - 500;
    return rand_angle();
  endfunction

  function automatic int small_angle();
    return int'($urandom_range(0, 400)) - 200;
  endfunction

  function automatic tick_t random_tick();
    int wr, wp, wy, thr;
    wr = rand_angle();
    wp = rand_angle();
    wy = rand_angle();
    if ($urandom_range(0, 4) == 0) thr = $urandom_range(0, 100);
    else thr = $urandom_range(0, 1023);
    return make_tick($urandom_range(0, 7) != 0, near_angle(wr), near_angle(wp), near_angle(wy),
                     wr, wp, wy, thr);
  endfunction

  function automatic gain_t rand_gain();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return gain_t'($urandom());
      default: return gain_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic gains_t rand_gains();
    return {rand_gain(), rand_gain(), rand_gain()};
  endfunction

  function automatic gains_t junk_above(int bits);
    gains_t d;
    d = gains_t'({$urandom(), $urandom()});
    return d >> bits << bits;
  endfunction

  task automatic write_reg(apmm_pkg::cfg_idx_e idx, gains_t data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      apmm_pkg::CFG_ROLL_GAINS:    gains_q[AX_ROLL] = data;
      apmm_pkg::CFG_PITCH_GAINS:   gains_q[AX_PITCH] = data;
      apmm_pkg::CFG_YAW_GAINS:     gains_q[AX_YAW] = data;
      apmm_pkg::CFG_THROTTLE_IDLE: idle_q = data[apmm_pkg::THR_W-1:0];
      apmm_pkg::CFG_PWM_HIGH:      pwm_high_q = data[apmm_pkg::PWM_W-1:0];
      apmm_pkg::CFG_VEHICLE_TYPE:  vehicle_q = apmm_pkg::vehicle_e'(data[0]);
      default: ;
    endcase
  endtask

  task automatic send_tick(tick_t t);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = tx_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i      <= 1'b1;
    armed_i         <= t.armed;
    meas_roll_i     <= t.meas_roll;
    meas_pitch_i    <= t.meas_pitch;
    meas_yaw_i      <= t.meas_yaw;
    want_roll_i     <= t.want_roll;
    want_pitch_i    <= t.want_pitch;
    want_yaw_i      <= t.want_yaw;
    want_throttle_i <= t.want_throttle;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pwm_expected.push_back(predict_tick(t));
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pwm_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // reset configuration, held zeros, low throttle idle, disarm
  task automatic test_reset_defaults();
    send_tick(make_tick(1'b1, 0, 0, 0, 0, 0, 0, 500));
    send_tick(make_tick(1'b1, 100, -100, 50, 0, 0, 0, THR_IDLE_BELOW - 1));
    send_tick(make_tick(1'b0, 0, 0, 0, 0, 0, 0, 500));
    send_tick(make_tick(1'b1, 0, 0, 0, 0, 0, 0, THR_IDLE_BELOW));
  endtask

  task automatic test_directed();
    drain();
    write_reg(apmm_pkg::CFG_ROLL_GAINS, {16'h0200, 16'h0001, 16'h0100});
    write_reg(apmm_pkg::CFG_PITCH_GAINS, {16'h0000, 16'h0000, 16'h0080});
    write_reg(apmm_pkg::CFG_YAW_GAINS, {16'h0100, 16'h0000, 16'h0040});
    write_reg(apmm_pkg::CFG_THROTTLE_IDLE, gains_t'(1000));
    write_reg(apmm_pkg::CFG_PWM_HIGH, gains_t'(2047));
    send_tick(make_tick(1'b1, 0, 0, 0, 0, 0, 0, 1023));
    send_tick(make_tick(1'b1, 18000, 0, 0, -18000, 0, 0, 500));
    send_tick(make_tick(1'b1, -18000, 18000, 0, 18000, -18000, 0, 500));
    // yaw error wrap at both ends of the half turn
    send_tick(make_tick(1'b1, 0, 0, 18000, 0, 0, -18000, 300));
    send_tick(make_tick(1'b1, 0, 0, -18000, 0, 0, 0, 300));
    send_tick(make_tick(1'b1, 0, 0, 0, 0, 0, -18000, 300));
    // raw angles outside the nominal range
    send_tick(make_tick(1'b1, -32768, 0, 32767, 32767, 0, -32768, 300));
    send_tick(make_tick(1'b0, 1234, -555, 777, 0, 0, 0, 300));
    send_tick(make_tick(1'b1, 40, -30, 20, 0, 0, 0, 200));
    // upper clamp below the floor wins
    drain();
    write_reg(apmm_pkg::CFG_PWM_HIGH, gains_t'(500));
    send_tick(make_tick(1'b1, 10, 10, 10, 0, 0, 0, 600));
    send_tick(make_tick(1'b0, 0, 0, 0, 0, 0, 0, 600));
    send_tick(make_tick(1'b1, 0, 0, 0, 0, 0, 0, 600));
    drain();
    write_reg(apmm_pkg::CFG_PWM_HIGH, gains_t'(2047));
    write_reg(apmm_pkg::CFG_VEHICLE_TYPE, gains_t'(apmm_pkg::VEH_PAIR));
    send_tick(make_tick(1'b1, 0, 0, 300, 0, 0, 0, 0));
    send_tick(make_tick(1'b1, 0, 0, -300, 0, 0, 0, 1023));
    send_tick(make_tick(1'b0, 0, 0, 0, 0, 0, 0, 500));
    send_tick(make_tick(1'b1, 0, 0, 50, 0, 0, 0, THR_IDLE_BELOW - 1));
    drain();
    write_reg(apmm_pkg::CFG_VEHICLE_TYPE, gains_t'(apmm_pkg::VEH_QUAD_X));
    send_tick(make_tick(1'b1, 20, 20, 20, 0, 0, 0, THR_IDLE_BELOW - 1));
    send_tick(make_tick(1'b1, 20, 20, 20, 0, 0, 0, THR_IDLE_BELOW));
  endtask

  // drive the roll integrator into both limits, then walk it back near zero
  task automatic test_integrator_limits();
    int n;
    drain();
    write_reg(apmm_pkg::CFG_ROLL_GAINS, {16'h0000, 16'hFFFF, 16'h0000});
    write_reg(apmm_pkg::CFG_PITCH_GAINS, {16'h0000, 16'h0000, 16'h0040});
    write_reg(apmm_pkg::CFG_YAW_GAINS, {16'h0000, 16'h0000, 16'h0040});
    write_reg(apmm_pkg::CFG_THROTTLE_IDLE, gains_t'(100));
    for (n = 0; n < 150; n++)
      send_tick(make_tick(1'b1, 32767, small_angle(), small_angle(), -32768, 0, 0, 500));
    for (n = 0; n < 300; n++)
      send_tick(make_tick(1'b1, -32768, small_angle(), small_angle(), 32767, 0, 0, 500));
    for (n = 0; n < 128; n++)
      send_tick(make_tick(1'b1, 32767, small_angle(), small_angle(), -32768, 0, 0, 500));
    send_tick(make_tick(1'b1, 256, 0, 0, 0, 0, 0, 500));
    send_tick(make_tick(1'b1, 0, 0, 0, 0, 0, 0, 500));
  endtask

  // receiver holds off while requests keep coming, so the input must stall
  task automatic test_backpressure();
    int n;
    drain();
    tx_steady = 1'b1;
    hold_len  = 120;
    hold_seq++;
    for (n = 0; n < 40; n++) send_tick(random_tick());
    tx_steady = 1'b0;
  endtask

  task automatic test_random_phases();
    int     ph, n;
    gains_t d;
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      if (ph == 0) begin
        write_reg(apmm_pkg::CFG_ROLL_GAINS, '0);
        write_reg(apmm_pkg::CFG_PITCH_GAINS, '0);
        write_reg(apmm_pkg::CFG_YAW_GAINS, '0);
        write_reg(apmm_pkg::CFG_THROTTLE_IDLE, '0);
        write_reg(apmm_pkg::CFG_PWM_HIGH, gains_t'(PWM_FLOOR));
        write_reg(apmm_pkg::CFG_VEHICLE_TYPE, gains_t'(apmm_pkg::VEH_QUAD_X));
      end else if (ph == NUM_PHASES - 1) begin
        write_reg(apmm_pkg::CFG_ROLL_GAINS, '1);
        write_reg(apmm_pkg::CFG_PITCH_GAINS, '1);
        write_reg(apmm_pkg::CFG_YAW_GAINS, '1);
        write_reg(apmm_pkg::CFG_THROTTLE_IDLE, gains_t'(10'h3FF));
        write_reg(apmm_pkg::CFG_PWM_HIGH, gains_t'(11'h7FF));
        write_reg(apmm_pkg::CFG_VEHICLE_TYPE, gains_t'($urandom_range(0, 1)));
      end else begin
        write_reg(apmm_pkg::CFG_ROLL_GAINS, rand_gains());
        write_reg(apmm_pkg::CFG_PITCH_GAINS, rand_gains());
        write_reg(apmm_pkg::CFG_YAW_GAINS, rand_gains());
        d = junk_above(apmm_pkg::THR_W);
        d[apmm_pkg::THR_W-1:0] = thr_t'($urandom_range(0, 1023));
        write_reg(apmm_pkg::CFG_THROTTLE_IDLE, d);
        d = junk_above(apmm_pkg::PWM_W);
        case ($urandom_range(0, 9))
          0: d[apmm_pkg::PWM_W-1:0] = pwm_t'($urandom_range(0, PWM_FLOOR - 1));
          1: d[apmm_pkg::PWM_W-1:0] = pwm_t'(PWM_FLOOR);
          2: d[apmm_pkg::PWM_W-1:0] = '1;
          default: d[apmm_pkg::PWM_W-1:0] = pwm_t'($urandom_range(PWM_FLOOR, 2047));
        endcase
        write_reg(apmm_pkg::CFG_PWM_HIGH, d);
        d = junk_above(1);
        d[0] = 1'($urandom_range(0, 1));
        write_reg(apmm_pkg::CFG_VEHICLE_TYPE, d);
      end
      tx_steady = ($urandom_range(0, 3) == 0);
      for (n = 0; n < PHASE_TICKS; n++) send_tick(random_tick());
      tx_steady = 1'b0;
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case (rx_mode)
        RX_FREE:  out_stall_i <= 1'b0;
        RX_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall_i <= ($urandom_range(0, 9) < 6);
        default:  out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_got = {throttle_pwm_o, yaw_pwm_o, back_right_pwm_o, back_left_pwm_o,
                    front_right_pwm_o, front_left_pwm_o};
      if (pwm_expected.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS) $display("result with no request pending at %0t", $time);
      end else begin
        result_want = pwm_expected.pop_front();
        for (int i = 0; i < NUM_PWM; i++) begin
          if (result_got[i] !== result_want[i]) begin
            failures++;
            if (failures <= MAX_REPORTS)
              $display("%s mismatch at %0t: expected %0d, got %0d", pwm_name[i], $time,
                       result_want[i], result_got[i]);
          end
        end
      end
    end
  end

  initial begin
    #(RUN_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    for (int a = 0; a < NUM_AXES; a++) begin
      gains_q[a]  = '0;
      prev_err[a] = 0;
      integ[a]    = 0;
    end
    idle_q     = '0;
    pwm_high_q = pwm_t'(apmm_pkg::PWM_HIGH_RST);
    vehicle_q  = apmm_pkg::VEH_QUAD_X;
    held_pwm   = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_directed();
    test_integrator_limits();
    test_backpressure();
    test_random_phases();
    drain();
    if (failures == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/apmm_pkg.sv
rtl/core/attitude_pid_motor_mixer_top.sv
tb/tb_top.sv
